// ===== design/circular_list_josephus_engine_macros.svh =====
// Assertion macros for the circular list Josephus engine.
// Clocked on clk_i and disabled while rst_ni is low; no other dependencies.
`ifndef CIRCULAR_LIST_JOSEPHUS_ENGINE_MACROS_SVH
`define CIRCULAR_LIST_JOSEPHUS_ENGINE_MACROS_SVH

// Same-cycle implication.
`define CLE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CLE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/cle_pkg.sv =====
// Shared types and constants for the circular list Josephus engine.
// No dependencies; used by the interfaces, controller, datapath and top level.
`timescale 1ns / 1ps
`default_nettype none

package cle_pkg;

  localparam int unsigned LIST_DEPTH_DEF = 16;
  localparam int unsigned DATA_W         = 32;
  localparam int unsigned OP_W           = 3;
  localparam int unsigned STEP_W         = 8;
  localparam int unsigned STATUS_W       = 2;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND   = 3'd0,
    OP_INSERT   = 3'd1,
    OP_DELETE   = 3'd2,
    OP_JOSEPHUS = 3'd3,
    OP_READ_ALL = 3'd4
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 2'd0,
    STS_FULL      = 2'd1,
    STS_EMPTY     = 2'd2,
    STS_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    IDX_HOLD, IDX_ZERO, IDX_COUNT, IDX_REM, IDX_INC, IDX_DEC
  } idx_op_e;

  typedef enum logic [1:0] {RA_IDX, RA_IDX_DEC, RA_IDX_INC, RA_ZERO} rd_addr_e;
  typedef enum logic [1:0] {WA_IDX, WA_COUNT, WA_ZERO} wr_addr_e;
  typedef enum logic {WD_OPERAND, WD_RDATA} wr_data_e;
  typedef enum logic [1:0] {CNT_HOLD, CNT_INC, CNT_DEC} cnt_op_e;
  typedef enum logic [1:0] {POS_HOLD, POS_ZERO, POS_REM, POS_WRAP} pos_op_e;
  typedef enum logic [1:0] {REM_HOLD, REM_LOAD, REM_SUB} rem_op_e;

  // controller -> datapath
  typedef struct packed {
    logic     capture;
    idx_op_e  idx_op;
    logic     rd_en;
    rd_addr_e rd_addr;
    logic     wr_en;
    wr_addr_e wr_addr;
    wr_data_e wr_data;
    cnt_op_e  cnt_op;
    pos_op_e  pos_op;
    rem_op_e  rem_op;
    logic     emit;
    logic     emit_rdata;
    status_e  emit_status;
    logic     emit_last;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    opcode_e opcode;
    logic    full;
    logic    empty;
    logic    single;
    logic    idx_zero;
    logic    idx_last;
    logic    match;
    logic    rem_ge;
    logic    out_busy;
  } sts_t;

endpackage

`default_nettype wire

// ===== design/cle_if.sv =====
// Valid/ready channel interfaces: request side and result side.
// Depends on cle_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface cle_in_if;
  import cle_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          opcode;
  logic signed [DATA_W-1:0] operand_value;
  logic [STEP_W-1:0]        step_count;

  modport source (output valid, output opcode, output operand_value, output step_count,
                  input ready);
  modport sink   (input valid, input opcode, input operand_value, input step_count,
                  output ready);
endinterface

interface cle_out_if;
  import cle_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] result_value;
  logic [STATUS_W-1:0]      status;
  logic                     last_result;

  modport source (output valid, output result_value, output status, output last_result,
                  input ready);
  modport sink   (input valid, input result_value, input status, input last_result,
                  output ready);
endinterface

`default_nettype wire

// ===== design/cle_ctrl.sv =====
// Sequencing controller for the circular list engine.
// Depends on cle_pkg; drives cle_datapath through cmd_t and reads sts_t.
`timescale 1ns / 1ps
`default_nettype none

module cle_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire cle_pkg::sts_t sts_i,
  output cle_pkg::cmd_t      cmd_o
);
  import cle_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_INS_CHK, S_INS_WR, S_DEL_RD, S_DEL_CMP,
    S_RM_CHK, S_RM_WR, S_JO_LOOP, S_JO_MOD, S_JO_WRAP, S_JO_EMIT,
    S_RD_RD, S_RD_EMIT, S_EMIT
  } state_e;

  state_e  state_q, state_d;
  status_e st_q, st_d;
  logic    jos_q, jos_d;   // removal belongs to a Josephus run

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      st_q    <= STS_OK;
      jos_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
      jos_q   <= jos_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    st_d       = st_q;
    jos_d      = jos_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts_i.opcode)
          OP_APPEND: begin
            state_d = S_EMIT;
            if (sts_i.full) begin
              st_d = STS_FULL;
            end else begin
              cmd_o.wr_en   = 1'b1;
              cmd_o.wr_addr = WA_COUNT;
              cmd_o.wr_data = WD_OPERAND;
              cmd_o.cnt_op  = CNT_INC;
              st_d          = STS_OK;
            end
          end
          OP_INSERT: begin
            if (sts_i.full) begin
              st_d    = STS_FULL;
              state_d = S_EMIT;
            end else begin
              cmd_o.idx_op = IDX_COUNT;
              state_d      = S_INS_CHK;
            end
          end
          OP_DELETE: begin
            if (sts_i.empty) begin
              st_d    = STS_EMPTY;
              state_d = S_EMIT;
            end else begin
              cmd_o.idx_op = IDX_ZERO;
              jos_d        = 1'b0;
              state_d      = S_DEL_RD;
            end
          end
          OP_JOSEPHUS: begin
            if (sts_i.empty) begin
              st_d    = STS_EMPTY;
              state_d = S_EMIT;
            end else begin
              cmd_o.pos_op = POS_ZERO;
              jos_d        = 1'b1;
              state_d      = S_JO_LOOP;
            end
          end
          OP_READ_ALL: begin
            if (sts_i.empty) begin
              st_d    = STS_EMPTY;
              state_d = S_EMIT;
            end else begin
              cmd_o.idx_op = IDX_ZERO;
              state_d      = S_RD_RD;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      // shift entries up one place, tail first
      S_INS_CHK: begin
        if (sts_i.idx_zero) begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_addr = WA_ZERO;
          cmd_o.wr_data = WD_OPERAND;
          cmd_o.cnt_op  = CNT_INC;
          st_d          = STS_OK;
          state_d       = S_EMIT;
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = RA_IDX_DEC;
          state_d       = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = WA_IDX;
        cmd_o.wr_data = WD_RDATA;
        cmd_o.idx_op  = IDX_DEC;
        state_d       = S_INS_CHK;
      end
      S_DEL_RD: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = RA_IDX;
        state_d       = S_DEL_CMP;
      end
      S_DEL_CMP: begin
        if (sts_i.match) begin
          state_d = S_RM_CHK;
        end else if (sts_i.idx_last) begin
          st_d    = STS_NOT_FOUND;
          state_d = S_EMIT;
        end else begin
          cmd_o.idx_op = IDX_INC;
          state_d      = S_DEL_RD;
        end
      end
      // close the gap at idx, head side first
      S_RM_CHK: begin
        if (sts_i.idx_last) begin
          cmd_o.cnt_op = CNT_DEC;
          if (jos_q) begin
            state_d = S_JO_WRAP;
          end else begin
            st_d    = STS_OK;
            state_d = S_EMIT;
          end
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = RA_IDX_INC;
          state_d       = S_RM_WR;
        end
      end
      S_RM_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = WA_IDX;
        cmd_o.wr_data = WD_RDATA;
        cmd_o.idx_op  = IDX_INC;
        state_d       = S_RM_CHK;
      end
      S_JO_LOOP: begin
        if (sts_i.single) begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = RA_ZERO;
          state_d       = S_JO_EMIT;
        end else begin
          cmd_o.rem_op = REM_LOAD;
          state_d      = S_JO_MOD;
        end
      end
      S_JO_MOD: begin
        if (sts_i.rem_ge) begin
          cmd_o.rem_op = REM_SUB;
        end else begin
          cmd_o.idx_op = IDX_REM;
          cmd_o.pos_op = POS_REM;
          state_d      = S_RM_CHK;
        end
      end
      S_JO_WRAP: begin
        cmd_o.pos_op = POS_WRAP;
        state_d      = S_JO_LOOP;
      end
      S_JO_EMIT: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_rdata  = 1'b1;
          cmd_o.emit_status = STS_OK;
          cmd_o.emit_last   = 1'b1;
          state_d           = S_IDLE;
        end
      end
      S_RD_RD: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = RA_IDX;
        state_d       = S_RD_EMIT;
      end
      S_RD_EMIT: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_rdata  = 1'b1;
          cmd_o.emit_status = STS_OK;
          cmd_o.emit_last   = sts_i.idx_last;
          if (sts_i.idx_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.idx_op = IDX_INC;
            state_d      = S_RD_RD;
          end
        end
      end
      S_EMIT: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = st_q;
          cmd_o.emit_last   = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/cle_datapath.sv =====
// Datapath: list memory, count, walk index, Josephus position and result register.
// Depends on cle_pkg and the assertion macro header; driven by cle_ctrl.
`timescale 1ns / 1ps
`default_nettype none
`include "circular_list_josephus_engine_macros.svh"

module cle_datapath #(
  parameter int unsigned LIST_DEPTH = cle_pkg::LIST_DEPTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic [cle_pkg::OP_W-1:0]          opcode_i,
  input  wire logic signed [cle_pkg::DATA_W-1:0] operand_i,
  input  wire logic [cle_pkg::STEP_W-1:0]        step_i,
  input  wire cle_pkg::cmd_t                     cmd_i,
  output cle_pkg::sts_t                          sts_o,
  input  wire logic                              out_ready_i,
  output logic                                   out_valid_o,
  output logic signed [cle_pkg::DATA_W-1:0]      result_value_o,
  output logic [cle_pkg::STATUS_W-1:0]           status_o,
  output logic                                   last_result_o
);
  import cle_pkg::*;

  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
  localparam int unsigned AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned RW = $clog2(LIST_DEPTH + 256);

  logic [DATA_W-1:0] mem_q [LIST_DEPTH];
  logic [DATA_W-1:0] rdata_q;
  logic [OP_W-1:0]   opcode_q;
  logic [DATA_W-1:0] operand_q;
  logic [STEP_W-1:0] step_q;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic [CW-1:0]     pos_q, pos_d;
  logic [RW-1:0]     rem_q, rem_d;
  logic [RW-1:0]     adv;
  logic [CW-1:0]     rd_idx, wr_idx;
  logic [DATA_W-1:0] wr_data;
  logic [CW:0]       idx_nx;
  logic              full;
  logic              rem_ge;

  logic                 out_valid_q;
  logic [DATA_W-1:0]    result_q;
  logic [STATUS_W-1:0]  status_q;
  logic                 last_q;

  // step k advances k-1 places, step zero behaves as one
  assign adv    = (step_q == '0) ? '0 : (RW'(step_q) - RW'(1));
  assign idx_nx = {1'b0, idx_q} + {{CW{1'b0}}, 1'b1};
  assign full   = (cnt_q == CW'(LIST_DEPTH));
  assign rem_ge = (rem_q >= RW'(cnt_q));

  assign sts_o.opcode   = opcode_e'(opcode_q);
  assign sts_o.full     = full;
  assign sts_o.empty    = (cnt_q == '0);
  assign sts_o.single   = (cnt_q <= CW'(1));
  assign sts_o.idx_zero = (idx_q == '0);
  assign sts_o.idx_last = (idx_nx >= {1'b0, cnt_q});
  assign sts_o.match    = (rdata_q == operand_q);
  assign sts_o.rem_ge   = rem_ge;
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

  always_comb begin
    case (cmd_i.rd_addr)
      RA_IDX:     rd_idx = idx_q;
      RA_IDX_DEC: rd_idx = idx_q - CW'(1);
      RA_IDX_INC: rd_idx = idx_q + CW'(1);
      default:    rd_idx = '0;
    endcase
    case (cmd_i.wr_addr)
      WA_IDX:   wr_idx = idx_q;
      WA_COUNT: wr_idx = cnt_q;
      default:  wr_idx = '0;
    endcase
    wr_data = (cmd_i.wr_data == WD_RDATA) ? rdata_q : operand_q;
  end

  always_comb begin
    case (cmd_i.idx_op)
      IDX_ZERO:  idx_d = '0;
      IDX_COUNT: idx_d = cnt_q;
      IDX_REM:   idx_d = rem_q[CW-1:0];
      IDX_INC:   idx_d = idx_q + CW'(1);
      IDX_DEC:   idx_d = idx_q - CW'(1);
      default:   idx_d = idx_q;
    endcase
    case (cmd_i.cnt_op)
      CNT_INC: cnt_d = cnt_q + CW'(1);
      CNT_DEC: cnt_d = cnt_q - CW'(1);
      default: cnt_d = cnt_q;
    endcase
    case (cmd_i.pos_op)
      POS_ZERO: pos_d = '0;
      POS_REM:  pos_d = rem_q[CW-1:0];
      POS_WRAP: pos_d = (pos_q >= cnt_q) ? '0 : pos_q;
      default:  pos_d = pos_q;
    endcase
    // modulo by the live count: one conditional subtract per cycle
    case (cmd_i.rem_op)
      REM_LOAD: rem_d = RW'(pos_q) + adv;
      REM_SUB:  rem_d = rem_q - RW'(cnt_q);
      default:  rem_d = rem_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[wr_idx[AW-1:0]] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[rd_idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      opcode_q  <= opcode_i;
      operand_q <= operand_i;
      step_q    <= step_i;
    end
    pos_q <= pos_d;
    rem_q <= rem_d;
    if (cmd_i.emit) begin
      result_q <= cmd_i.emit_rdata ? rdata_q : '0;
      status_q <= cmd_i.emit_status;
      last_q   <= cmd_i.emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = result_q;
  assign status_o       = status_q;
  assign last_result_o  = last_q;

  `CLE_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CW'(LIST_DEPTH), "entry count above depth")
  `CLE_ASSERT_IMP(a_wr_range, cmd_i.wr_en, wr_idx <= cnt_q, "write beyond list tail")
  `CLE_ASSERT_IMP(a_inc_room, cmd_i.cnt_op == CNT_INC, !full, "count increment on full list")
  `CLE_ASSERT_IMP(a_rem_sub, cmd_i.rem_op == REM_SUB, rem_ge, "modulo subtract underflow")
  `CLE_ASSERT_NXT(a_emit_valid, cmd_i.emit, out_valid_q, "emitted result not presented")

endmodule

`default_nettype wire

// ===== design/circular_list_josephus_engine.sv =====
// Top level of the circular list Josephus engine.
// Depends on cle_pkg, cle_if (cle_in_if, cle_out_if), cle_ctrl and cle_datapath.
//
//   channel | dir | handshake   | payload
//   --------+-----+-------------+-----------------------------------------
//   in_i    | in  | valid/ready | opcode, operand_value, step_count
//   out_o   | out | valid/ready | result_value, status, last_result
//
// One operation at a time. Insert, delete and each Josephus removal shift
// entries through the list memory: every shift moves one entry by a read
// and then a write, and the Josephus modulo is one subtract a cycle.
// Reset (rst_ni low, asynchronous) empties the list; entry contents are not
// cleared and need no clearing pass.
// A result waits in the output register while the output stalls; the next
// input transaction is taken as soon as the last result of the previous one
// is loaded there.
`timescale 1ns / 1ps
`default_nettype none

module circular_list_josephus_engine #(
  parameter int unsigned LIST_DEPTH = cle_pkg::LIST_DEPTH_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cle_in_if.sink    in_i,
  cle_out_if.source out_o
);
  import cle_pkg::*;

  cmd_t cmd;   // controller commands
  sts_t sts;   // datapath flags

  // controller: sequencing only, no list data passes through it
  cle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: list storage, counters and the output register
  cle_datapath #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .opcode_i       (in_i.opcode),
    .operand_i      (in_i.operand_value),
    .step_i         (in_i.step_count),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .result_value_o (out_o.result_value),
    .status_o       (out_o.status),
    .last_result_o  (out_o.last_result)
  );

endmodule

`default_nettype wire
